@@ src/lru_cache_with_neighbor_query_unit_defines.svh @@
// Assertion macros for the LRU cache with neighbor query unit.
// Included by the checker module; no other dependencies.
`ifndef LRU_CACHE_WITH_NEIGHBOR_QUERY_UNIT_DEFINES_SVH
`define LRU_CACHE_WITH_NEIGHBOR_QUERY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCNQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcnq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCNQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcnq assertion failed");

// Next-cycle implication that also holds across reset.
`define LCNQ_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lcnq assertion failed");

`endif

@@ src/lcnq_pkg.sv @@
// Shared constants and codes for the LRU cache with neighbor query unit.
// No dependencies.
`timescale 1ns / 1ps

package lcnq_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int CAP_CFG_W    = 9;
    localparam int DIGITS_W     = 34;
    localparam int LENGTH_W     = 4;
    localparam int KEY_W        = DIGITS_W + LENGTH_W;
    localparam int VALUE_W      = 32;
    localparam int OFFSET_W     = 2;
    localparam int S_TDATA_W    = 72;
    localparam int M_TDATA_W    = 32;

    localparam logic [CAP_CFG_W-1:0] CAP_RESET = 9'd256;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_ACCESS = 1'b1;

    localparam logic [OFFSET_W-1:0] OFF_SELF     = 2'b00;
    localparam logic [OFFSET_W-1:0] OFF_NEWER    = 2'b01;
    // This pattern has no neighbor meaning; a query with it answers invalid.
    localparam logic [OFFSET_W-1:0] OFF_RESERVED = 2'b10;
    localparam logic [OFFSET_W-1:0] OFF_OLDER    = 2'b11;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;
endpackage

@@ src/lru_cache_with_neighbor_query_unit.sv @@
// Channel  Ports                          Contents
// input    s_tvalid s_tready s_tdata      tuser: kind; tdata: digits, length, value, offset
//          s_tuser
// result   m_tvalid m_tready m_tdata      tuser: status; tdata: result value
//          m_tuser
// config   cfg_we cfg_wdata               capacity in use
//
// An item finishes sooner on an early hit than after a full scan: the key
// memory is scanned one entry per cycle, then link reads and writes follow.
// One item is in work at a time; the result register lets the next item
// start while a result waits. Reset empties the table at once via valid bits.
// Depends on lcnq_pkg and lcnq_ram.
`timescale 1ns / 1ps

module lru_cache_with_neighbor_query_unit #(
    parameter int CAPACITY = lcnq_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: key_digits[33:0], key_length[37:34], new_value[69:38], offset[71:70]
    input  logic [lcnq_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: kind[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: result_value[31:0]
    output logic [lcnq_pkg::M_TDATA_W-1:0]      m_tdata,
    // tuser: status[0]
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [lcnq_pkg::CAP_CFG_W-1:0]      cfg_wdata
);
    import lcnq_pkg::*;

    localparam int IW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CAP_CFG_W) ? CNT_W : CAP_CFG_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_LREAD  = 4'd2;
    localparam logic [3:0] ST_LWAIT  = 4'd3;
    localparam logic [3:0] ST_QREAD  = 4'd4;
    localparam logic [3:0] ST_QWAIT  = 4'd5;
    localparam logic [3:0] ST_UNLINK = 4'd6;
    localparam logic [3:0] ST_APPEND = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [IW:0]         scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       pidx_reg, pidx_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_reg, free_next;
    logic                hit_reg, hit_next;
    logic                unl_reg, unl_next;
    logic                qok_reg, qok_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic                kind_reg, kind_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VALUE_W-1:0]  nv_reg, nv_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [IW-1:0]       o_reg, o_next;
    logic [IW-1:0]       n_reg, n_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [IW-1:0]       oldest_reg, oldest_next;
    logic [IW-1:0]       newest_reg, newest_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAP_CFG_W-1:0] cap_reg, cap_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]  m_data_reg, m_data_next;
    logic                m_status_reg, m_status_next;

    logic [KEY_W-1:0]    key_rdata;
    logic [VALUE_W-1:0]  value_rdata;
    logic [IW-1:0]       older_rdata, newer_rdata;
    logic                older_we, newer_we, entry_we;
    logic [IW-1:0]       older_waddr, newer_waddr, older_wdata, newer_wdata;

    logic [CMP_W-1:0]    cap_ext, eff_cap;
    logic                full;
    logic                scan_in;
    logic                in_accept;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_status_reg;

    // Capacity 0 behaves as 1, anything above the table size as the table size.
    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(CAPACITY)) begin
            eff_cap = CMP_W'(CAPACITY);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign full    = (CMP_W'(count_reg) >= eff_cap) && (count_reg != '0);
    assign scan_in = (scan_idx_reg < (IW + 1)'(CAPACITY));

    lcnq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .aclk(aclk), .we(entry_we), .waddr(slot_reg), .wdata(key_reg),
        .raddr(scan_idx_reg[IW-1:0]), .rdata(key_rdata)
    );
    lcnq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
        .aclk(aclk), .we(entry_we), .waddr(slot_reg), .wdata(nv_reg),
        .raddr(slot_reg), .rdata(value_rdata)
    );
    lcnq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_older_ram (
        .aclk(aclk), .we(older_we), .waddr(older_waddr), .wdata(older_wdata),
        .raddr(slot_reg), .rdata(older_rdata)
    );
    lcnq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_newer_ram (
        .aclk(aclk), .we(newer_we), .waddr(newer_waddr), .wdata(newer_wdata),
        .raddr(slot_reg), .rdata(newer_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        hit_next        = hit_reg;
        unl_next        = unl_reg;
        qok_next        = qok_reg;
        slot_next       = slot_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        nv_next         = nv_reg;
        off_next        = off_reg;
        o_next          = o_reg;
        n_next          = n_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        valid_next      = valid_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        count_next      = count_reg;
        cap_next        = cfg_we ? cfg_wdata : cap_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        older_we        = 1'b0;
        newer_we        = 1'b0;
        entry_we        = 1'b0;
        older_waddr     = n_reg;
        older_wdata     = o_reg;
        newer_waddr     = o_reg;
        newer_wdata     = n_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    kind_next       = s_tuser[0];
                    key_next        = {s_tdata[33:0], s_tdata[37:34]};
                    nv_next         = s_tdata[69:38];
                    off_next        = s_tdata[71:70];
                    scan_idx_next   = '0;
                    pend_next       = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The compare works on the entry read in the previous cycle.
                if (pend_reg && (key_rdata == key_reg)) begin
                    hit_next   = 1'b1;
                    unl_next   = 1'b1;
                    slot_next  = pidx_reg;
                    state_next = ST_LREAD;
                end else if (!scan_in) begin
                    hit_next   = 1'b0;
                    unl_next   = full;
                    slot_next  = full ? oldest_reg : free_reg;
                    state_next = ST_LREAD;
                end else begin
                    pend_next = valid_reg[scan_idx_reg[IW-1:0]];
                    pidx_next = scan_idx_reg[IW-1:0];
                    if (!valid_reg[scan_idx_reg[IW-1:0]] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_next       = scan_idx_reg[IW-1:0];
                    end
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_LREAD: begin
                state_next = ST_LWAIT;
            end
            ST_LWAIT: begin
                o_next   = older_rdata;
                n_next   = newer_rdata;
                val_next = value_rdata;
                if (kind_reg == KIND_QUERY) begin
                    qok_next = hit_reg;
                    case (off_reg)
                        OFF_SELF: begin
                            slot_next = slot_reg;
                        end
                        OFF_NEWER: begin
                            if (slot_reg == newest_reg) qok_next = 1'b0;
                            slot_next = newer_rdata;
                        end
                        OFF_OLDER: begin
                            if (slot_reg == oldest_reg) qok_next = 1'b0;
                            slot_next = older_rdata;
                        end
                        default: begin
                            qok_next = 1'b0;
                        end
                    endcase
                    state_next = ST_QREAD;
                end else begin
                    state_next = unl_reg ? ST_UNLINK : ST_APPEND;
                end
            end
            ST_QREAD: begin
                state_next = ST_QWAIT;
            end
            ST_QWAIT: begin
                res_status_next = qok_reg ? STATUS_OK : STATUS_INVALID;
                res_value_next  = qok_reg ? value_rdata : '0;
                state_next      = ST_DONE;
            end
            ST_UNLINK: begin
                if (count_reg <= CNT_W'(1)) begin
                    count_next = '0;
                end else begin
                    if (slot_reg == oldest_reg) begin
                        oldest_next = n_reg;
                    end else if (slot_reg == newest_reg) begin
                        newest_next = o_reg;
                    end else begin
                        older_we = 1'b1;
                        newer_we = 1'b1;
                    end
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_APPEND;
            end
            ST_APPEND: begin
                if (count_reg == '0) begin
                    oldest_next = slot_reg;
                end else begin
                    older_we    = 1'b1;
                    older_waddr = slot_reg;
                    older_wdata = newest_reg;
                    newer_we    = 1'b1;
                    newer_waddr = newest_reg;
                    newer_wdata = slot_reg;
                end
                newest_next = slot_reg;
                count_next  = count_reg + 1'b1;
                if (!hit_reg) begin
                    entry_we              = 1'b1;
                    valid_next[slot_reg]  = 1'b1;
                end
                res_status_next = STATUS_OK;
                res_value_next  = hit_reg ? val_reg : nv_reg;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            oldest_reg   <= '0;
            newest_reg   <= '0;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            oldest_reg   <= oldest_next;
            newest_reg   <= newest_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        pend_reg       <= pend_next;
        pidx_reg       <= pidx_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        hit_reg        <= hit_next;
        unl_reg        <= unl_next;
        qok_reg        <= qok_next;
        slot_reg       <= slot_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        nv_reg         <= nv_next;
        off_reg        <= off_next;
        o_reg          <= o_next;
        n_reg          <= n_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
    end
endmodule

@@ src/lcnq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lcnq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/lcnq_checker.sv @@
// Port-level checker for the LRU cache with neighbor query unit, with its bind.
// Depends on lcnq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "lru_cache_with_neighbor_query_unit_defines.svh"

module lcnq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lcnq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import lcnq_pkg::*;

    `LCNQ_ASSERT_NXT_ALWAYS(a_reset_empties_out, aclk, !aresetn, !m_tvalid)
    `LCNQ_ASSERT_NXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // Only one item is in work, so the input closes right after a beat.
    `LCNQ_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // An invalid answer carries a zero value.
    `LCNQ_ASSERT_IMP(a_invalid_zero, aclk, aresetn,
        m_tvalid && (m_tuser[0] == STATUS_INVALID), m_tdata == '0)
endmodule

bind lru_cache_with_neighbor_query_unit lcnq_checker u_lcnq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

@@ sim/tb_lru_cache_with_neighbor_query_unit.sv @@
// Testbench for the LRU cache with neighbor query unit: directed and random beats
// checked against a behavioral LRU list kept inside the bench.
// Depends on lcnq_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_lru_cache_with_neighbor_query_unit;
    import lcnq_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic                 invalid;
        logic [VALUE_W-1:0]   value;
    } lru_answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [CAP_CFG_W-1:0] cfg_wdata = '0;

    lru_cache_with_neighbor_query_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Shadow copy of the table, kept in LRU order by explicit links.
    logic             shadow_valid [CAP];
    logic [KEY_W-1:0] shadow_key [CAP];
    logic [VALUE_W-1:0] shadow_value [CAP];
    int               shadow_older [CAP];
    int               shadow_newer [CAP];
    int               shadow_oldest, shadow_newest, shadow_fill;
    logic [CAP_CFG_W-1:0] shadow_capacity;

    lru_answer_t pending_answers[$];
    int  error_count = 0;
    int  answer_count = 0;
    int  cycle_count = 0;
    bit  idle_enabled = 1'b1;
    int  hold_off_cycles = 0;
    logic [KEY_W-1:0] recent_keys[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic list_unlink(input int s);
        if (shadow_fill <= 1) begin
            shadow_fill = 0;
            return;
        end
        if (s == shadow_oldest) begin
            shadow_oldest = shadow_newer[s];
        end else if (s == shadow_newest) begin
            shadow_newest = shadow_older[s];
        end else begin
            shadow_newer[shadow_older[s]] = shadow_newer[s];
            shadow_older[shadow_newer[s]] = shadow_older[s];
        end
        shadow_fill--;
    endtask

    task automatic list_append(input int s);
        if (shadow_fill == 0) begin
            shadow_oldest = s;
            shadow_newest = s;
        end else begin
            shadow_older[s] = shadow_newest;
            shadow_newer[shadow_newest] = s;
            shadow_newest = s;
        end
        shadow_fill++;
    endtask

    task automatic predict_lru(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] nv,
                               input logic [OFFSET_W-1:0] off, output lru_answer_t ans);
        int s;
        int cap_eff;
        bit hit;
        bit ok;
        s = 0;
        hit = 1'b0;
        for (int i = 0; i < CAP; i++) begin
            if (!hit && shadow_valid[i] && shadow_key[i] == key) begin
                s = i;
                hit = 1'b1;
            end
        end
        if (kind == KIND_QUERY) begin
            ok = hit;
            if (ok) begin
                if (off == OFF_OLDER) begin
                    if (s == shadow_oldest) ok = 1'b0;
                    else s = shadow_older[s];
                end else if (off == OFF_NEWER) begin
                    if (s == shadow_newest) ok = 1'b0;
                    else s = shadow_newer[s];
                end else if (off != OFF_SELF) begin
                    ok = 1'b0;
                end
            end
            ans.invalid = ok ? STATUS_OK : STATUS_INVALID;
            ans.value = ok ? shadow_value[s] : '0;
            return;
        end
        cap_eff = (shadow_capacity == 0) ? 1 : int'(shadow_capacity);
        if (cap_eff > CAP) cap_eff = CAP;
        if (hit) begin
            list_unlink(s);
            list_append(s);
        end else begin
            if (shadow_fill >= cap_eff && shadow_fill > 0) begin
                s = shadow_oldest;
                list_unlink(s);
                shadow_valid[s] = 1'b0;
            end else begin
                for (int i = CAP - 1; i >= 0; i--) begin
                    if (!shadow_valid[i]) s = i;
                end
            end
            shadow_valid[s] = 1'b1;
            shadow_key[s] = key;
            shadow_value[s] = nv;
            list_append(s);
        end
        ans.invalid = STATUS_OK;
        ans.value = shadow_value[s];
    endtask

    // Sends one beat; the expectation is queued when the beat is accepted.
    // Valid stays up after the beat unless an idle burst or a drain follows.
    task automatic send_item(input logic kind, input logic [DIGITS_W-1:0] digits,
                             input logic [LENGTH_W-1:0] len, input logic [VALUE_W-1:0] nv,
                             input logic [OFFSET_W-1:0] off);
        lru_answer_t ans;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {off, nv, len, digits};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_lru(kind, {digits, len}, nv, off, ans);
        pending_answers.push_back(ans);
        if (kind == KIND_ACCESS) begin
            recent_keys.push_back({digits, len});
            if (recent_keys.size() > 24) void'(recent_keys.pop_front());
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (CAP + 20) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_CFG_W-1:0] cap);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_capacity = cap;
    endtask

    // Mostly keys seen lately, so hits and neighbor queries are common.
    task automatic send_random(input int count, input int key_pool);
        logic [DIGITS_W-1:0] d;
        logic [LENGTH_W-1:0] l;
        logic [KEY_W-1:0] k;
        logic [OFFSET_W-1:0] off;
        for (int n = 0; n < count; n++) begin
            if (recent_keys.size() != 0 && $urandom_range(0, 9) < 6) begin
                k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                {d, l} = k;
            end else if ($urandom_range(0, 4) == 0) begin
                d = DIGITS_W'({$urandom, $urandom});
                l = LENGTH_W'($urandom);
            end else begin
                d = DIGITS_W'($urandom_range(0, key_pool));
                l = LENGTH_W'($urandom_range(1, 10));
            end
            off = OFFSET_W'($urandom);
            send_item(1'($urandom_range(0, 1)), d, l, $urandom, off);
        end
    endtask

    task automatic test_directed();
        send_item(KIND_QUERY, '0, 4'd1, '0, OFF_SELF);
        send_item(KIND_ACCESS, 34'd7, 4'd1, 32'h7FFF_FFFF, OFF_SELF);
        send_item(KIND_ACCESS, 34'd7, 4'd2, 32'h8000_0000, OFF_SELF);
        send_item(KIND_ACCESS, 34'd9999999999, 4'd10, 32'hFFFF_FFFF, OFF_SELF);
        send_item(KIND_ACCESS, 34'h3_FFFF_FFFF, 4'hF, 32'h1234_5678, OFF_OLDER);
        send_item(KIND_ACCESS, '0, 4'd0, 32'h0, OFF_SELF);
        send_item(KIND_ACCESS, 34'd7, 4'd1, 32'h5555_5555, OFF_SELF);
        send_item(KIND_QUERY, 34'd7, 4'd1, '0, OFF_SELF);
        send_item(KIND_QUERY, 34'd7, 4'd1, '0, OFF_NEWER);
        send_item(KIND_QUERY, 34'd7, 4'd1, '0, OFF_OLDER);
        send_item(KIND_QUERY, 34'd7, 4'd2, '0, OFF_OLDER);
        send_item(KIND_QUERY, 34'd7, 4'd2, '0, OFF_NEWER);
        send_item(KIND_QUERY, 34'd7, 4'd2, '0, OFF_RESERVED);
        send_item(KIND_QUERY, 34'd8, 4'd1, '0, OFF_SELF);
        send_item(KIND_QUERY, '0, 4'd0, 32'hFFFF_FFFF, OFF_NEWER);
    endtask

    task automatic test_small_capacity();
        write_capacity(9'd0);
        send_item(KIND_ACCESS, 34'd1, 4'd1, 32'd11, OFF_SELF);
        send_item(KIND_ACCESS, 34'd2, 4'd1, 32'd22, OFF_SELF);
        send_item(KIND_QUERY, 34'd2, 4'd1, '0, OFF_OLDER);
        write_capacity(9'd1);
        send_random(40, 4);
        write_capacity(9'd3);
        send_random(60, 8);
    endtask

    // The receiver holds off while beats keep coming, so the unit stalls its input.
    task automatic test_backpressure();
        write_capacity(9'd16);
        hold_off_cycles = 2000;
        send_random(30, 30);
        drain_results();
    endtask

    task automatic test_random_capacities();
        write_capacity(9'd511);
        send_random(120, 200);
        write_capacity(9'd256);
        send_random(80, 600);
        // Lowering below the fill keeps the fill where it stands.
        write_capacity(9'd5);
        send_random(80, 40);
        write_capacity(9'd8);
        idle_enabled = 1'b0;
        send_random(120, 20);
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < CAP; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_value[i] = '0;
            shadow_older[i] = 0;
            shadow_newer[i] = 0;
        end
        shadow_oldest = 0;
        shadow_newest = 0;
        shadow_fill = 0;
        shadow_capacity = CAP_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_small_capacity();
        test_backpressure();
        test_random_capacities();
        $display("Covered %0d results over capacities 0 to 511 with hits, evictions,",
                 answer_count);
        $display("neighbor queries, odd key patterns and a long receiver stall.");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                hold_off_cycles--;
            end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        lru_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            answer_count++;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata, 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_tuser[0] !== want.invalid)
                    report_mismatch("status", m_tuser, want.invalid);
                if (m_tdata !== want.value)
                    report_mismatch("result value", m_tdata, want.value);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout with %0d results outstanding", pending_answers.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end
endmodule
